// ----- design/rcrlc_pkg.sv -----
`default_nettype none

package rcrlc_pkg;

  localparam logic [2:0] OP_TICK         = 3'd0;
  localparam logic [2:0] OP_NEW_SESSION  = 3'd1;
  localparam logic [2:0] OP_DATA_PACKET  = 3'd2;
  localparam logic [2:0] OP_END_AUDIO    = 3'd3;
  localparam logic [2:0] OP_PLAYBACK_END = 3'd4;
  localparam logic [2:0] OP_CONFIRM      = 3'd5;
  localparam logic [2:0] OP_BEACON_HOLD  = 3'd6;

  localparam logic [2:0] REG_BLINK_HALF  = 3'd0;
  localparam logic [2:0] REG_PULSE       = 3'd1;
  localparam logic [2:0] REG_GAP_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_CONFIRM_HLD = 3'd3;
  localparam logic [2:0] REG_RETRY_WIN   = 3'd4;
  localparam logic [2:0] REG_MAX_ATTEMPT = 3'd5;
  localparam logic [2:0] REG_DEBOUNCE    = 3'd6;

  localparam logic [11:0] BLINK_HALF_RST  = 12'd220;
  localparam logic [11:0] PULSE_RST       = 12'd70;
  localparam logic [11:0] GAP_TIMEOUT_RST = 12'd300;
  localparam logic [15:0] CONFIRM_HLD_RST = 16'd2000;
  localparam logic [11:0] RETRY_WIN_RST   = 12'd350;
  localparam logic [2:0]  MAX_ATTEMPT_RST = 3'd3;
  localparam logic [7:0]  DEBOUNCE_RST    = 8'd25;

  localparam logic [15:0] ACK_HOLD_MS   = 16'd1500;
  localparam logic [15:0] EVENT_HOLD_MS = 16'd1000;
  localparam logic [15:0] SEND_HOLD_MS  = 16'd500;
  localparam logic [11:0] SINCE_MAX     = 12'd4095;

endpackage

`default_nettype wire

// ----- design/response_confirm_retry_led_control.sv -----
`default_nettype none

// Channel   Handshake                   Payload
// input     in_valid_i / in_ready_o     op_i, session_i, is_nack_i, button_level_i, hold_ms_i
// result    out_valid_o / out_ready_i   led_o, send_valid_o, send_session_o, send_is_nack_o,
//                                       confirm_matched_o, radio_busy_o
// config    psel/penable/pwrite         paddr, pwdata, prdata, pready (always high)
//
// The state and the result register update at the edge that accepts a request.
// One request per cycle is sustained while the result register is drained.
// A request is taken while a result waits, as long as that result leaves in the same cycle.
// Reset restores all register defaults and clears the state; the button is taken as released.

module response_confirm_retry_led_control
  import rcrlc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [63:0] session_i,
  input  wire logic        is_nack_i,
  input  wire logic        button_level_i,
  input  wire logic [15:0] hold_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             led_o,
  output logic             send_valid_o,
  output logic [63:0]      send_session_o,
  output logic             send_is_nack_o,
  output logic             confirm_matched_o,
  output logic             radio_busy_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [11:0] blink_half_q, pulse_cfg_q, gap_cfg_q, retry_cfg_q;
  logic [15:0] confirm_cfg_q;
  logic [2:0]  max_att_q;
  logic [7:0]  debounce_cfg_q;

  logic        nack_allowed_q, nack_allowed_d;
  logic        auto_ack_req_q, auto_ack_req_d;
  logic [63:0] auto_ack_sess_q, auto_ack_sess_d;
  logic [63:0] last_played_q, last_played_d;
  logic        awaiting_q, awaiting_d;
  logic        confirmed_q, confirmed_d;
  logic        pend_nack_q, pend_nack_d;
  logic [63:0] pend_sess_q, pend_sess_d;
  logic [15:0] confirm_left_q, confirm_left_d;
  logic        sess_active_q, sess_active_d;
  logic        data_started_q, data_started_d;
  logic [11:0] since_data_q, since_data_d;
  logic [11:0] pulse_left_q, pulse_left_d;
  logic [15:0] beacon_left_q, beacon_left_d;
  logic [12:0] blink_phase_q, blink_phase_d;
  logic [2:0]  attempts_q, attempts_d;
  logic [11:0] window_left_q, window_left_d;
  logic [7:0]  debounce_left_q, debounce_left_d;
  logic        debounce_act_q, debounce_act_d;
  logic        button_prev_q, button_prev_d;

  logic        out_valid_q;
  logic        led_q, led_d;
  logic        send_valid_q, send_valid_d;
  logic [63:0] send_sess_q, send_sess_d;
  logic        send_nack_q, send_nack_d;
  logic        matched_q, matched_d;
  logic        busy_q, busy_d;

  logic        start_go;
  logic        start_nack;
  logic [63:0] start_sess;
  logic        do_send;
  logic        accept;
  logic        cfg_write;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cfg_write  = psel && penable && pwrite;
  assign pready     = 1'b1;

  always_comb begin
    unique case (paddr[4:2])
      REG_BLINK_HALF:  prdata = {20'd0, blink_half_q};
      REG_PULSE:       prdata = {20'd0, pulse_cfg_q};
      REG_GAP_TIMEOUT: prdata = {20'd0, gap_cfg_q};
      REG_CONFIRM_HLD: prdata = {16'd0, confirm_cfg_q};
      REG_RETRY_WIN:   prdata = {20'd0, retry_cfg_q};
      REG_MAX_ATTEMPT: prdata = {29'd0, max_att_q};
      REG_DEBOUNCE:    prdata = {24'd0, debounce_cfg_q};
      default:         prdata = 32'd0;
    endcase
  end

  always_comb begin
    nack_allowed_d  = nack_allowed_q;
    auto_ack_req_d  = auto_ack_req_q;
    auto_ack_sess_d = auto_ack_sess_q;
    last_played_d   = last_played_q;
    awaiting_d      = awaiting_q;
    confirmed_d     = confirmed_q;
    pend_nack_d     = pend_nack_q;
    pend_sess_d     = pend_sess_q;
    confirm_left_d  = confirm_left_q;
    sess_active_d   = sess_active_q;
    data_started_d  = data_started_q;
    since_data_d    = since_data_q;
    pulse_left_d    = pulse_left_q;
    beacon_left_d   = beacon_left_q;
    blink_phase_d   = blink_phase_q;
    attempts_d      = attempts_q;
    window_left_d   = window_left_q;
    debounce_left_d = debounce_left_q;
    debounce_act_d  = debounce_act_q;
    button_prev_d   = button_prev_q;
    start_go        = 1'b0;
    start_nack      = 1'b0;
    start_sess      = 64'd0;
    do_send         = 1'b0;
    matched_d       = 1'b0;

    unique case (op_i)
      OP_TICK: begin
        confirm_left_d = (confirm_left_q != 16'd0) ? confirm_left_q - 16'd1 : 16'd0;
        pulse_left_d   = (pulse_left_q != 12'd0) ? pulse_left_q - 12'd1 : 12'd0;
        beacon_left_d  = (beacon_left_q != 16'd0) ? beacon_left_q - 16'd1 : 16'd0;
        if (since_data_q < SINCE_MAX) begin
          since_data_d = since_data_q + 12'd1;
        end
        if (awaiting_q && !confirmed_q) begin
          blink_phase_d = blink_phase_q + 13'd1;
          if (blink_phase_d >= {blink_half_q, 1'b0}) begin
            blink_phase_d = 13'd0;
          end
        end
        if (confirmed_q && confirm_left_d == 16'd0) begin
          confirmed_d = 1'b0;
          pend_nack_d = 1'b0;
          pend_sess_d = 64'd0;
        end
        if (awaiting_q) begin
          window_left_d = (window_left_q != 12'd0) ? window_left_q - 12'd1 : 12'd0;
          if (window_left_d == 12'd0) begin
            if (attempts_q < max_att_q) begin
              do_send = 1'b1;
            end else begin
              awaiting_d     = 1'b0;
              confirmed_d    = 1'b0;
              pend_nack_d    = 1'b0;
              pend_sess_d    = 64'd0;
              confirm_left_d = 16'd0;
              attempts_d     = 3'd0;
              window_left_d  = 12'd0;
            end
          end
        end else if (debounce_act_q) begin
          debounce_left_d = (debounce_left_q != 8'd0) ? debounce_left_q - 8'd1 : 8'd0;
          if (debounce_left_d == 8'd0) begin
            debounce_act_d = 1'b0;
            start_go       = !button_level_i;
            start_nack     = 1'b1;
            start_sess     = last_played_q;
          end
        end else begin
          auto_ack_req_d = 1'b0;
          if (auto_ack_req_q) begin
            start_go   = 1'b1;
            start_nack = 1'b0;
            start_sess = auto_ack_sess_q;
          end else if (nack_allowed_q && button_prev_q && !button_level_i) begin
            if (debounce_cfg_q == 8'd0) begin
              start_go   = 1'b1;
              start_nack = 1'b1;
              start_sess = last_played_q;
            end else begin
              debounce_act_d  = 1'b1;
              debounce_left_d = debounce_cfg_q;
            end
          end
          button_prev_d = button_level_i;
        end
        if (start_go && start_sess != 64'd0) begin
          awaiting_d     = 1'b1;
          confirmed_d    = 1'b0;
          confirm_left_d = 16'd0;
          pend_nack_d    = start_nack;
          pend_sess_d    = start_sess;
          beacon_left_d  = ACK_HOLD_MS;
          blink_phase_d  = 13'd0;
          attempts_d     = 3'd0;
          do_send        = 1'b1;
        end
        if (do_send) begin
          attempts_d    = attempts_d + 3'd1;
          window_left_d = retry_cfg_q;
          if (SEND_HOLD_MS > beacon_left_d) begin
            beacon_left_d = SEND_HOLD_MS;
          end
        end
      end
      OP_NEW_SESSION: begin
        nack_allowed_d  = 1'b0;
        auto_ack_req_d  = 1'b0;
        auto_ack_sess_d = 64'd0;
        last_played_d   = 64'd0;
        awaiting_d      = 1'b0;
        confirmed_d     = 1'b0;
        pend_nack_d     = 1'b0;
        pend_sess_d     = 64'd0;
        confirm_left_d  = 16'd0;
        attempts_d      = 3'd0;
        window_left_d   = 12'd0;
        sess_active_d   = 1'b1;
        data_started_d  = 1'b0;
        since_data_d    = 12'd0;
        pulse_left_d    = 12'd0;
        beacon_left_d   = ACK_HOLD_MS;
      end
      OP_DATA_PACKET: begin
        sess_active_d  = 1'b1;
        data_started_d = 1'b1;
        since_data_d   = 12'd0;
        pulse_left_d   = pulse_cfg_q;
        beacon_left_d  = EVENT_HOLD_MS;
      end
      OP_END_AUDIO: begin
        sess_active_d  = 1'b0;
        data_started_d = 1'b0;
        pulse_left_d   = 12'd0;
        beacon_left_d  = EVENT_HOLD_MS;
      end
      OP_PLAYBACK_END: begin
        if (session_i != 64'd0) begin
          last_played_d   = session_i;
          nack_allowed_d  = 1'b1;
          auto_ack_sess_d = session_i;
          auto_ack_req_d  = 1'b1;
          beacon_left_d   = ACK_HOLD_MS;
        end
      end
      OP_CONFIRM: begin
        if (awaiting_q && session_i == pend_sess_q && is_nack_i == pend_nack_q) begin
          confirmed_d    = 1'b1;
          awaiting_d     = 1'b0;
          attempts_d     = 3'd0;
          window_left_d  = 12'd0;
          confirm_left_d = confirm_cfg_q;
          nack_allowed_d = 1'b1;
          beacon_left_d  = EVENT_HOLD_MS;
          matched_d      = 1'b1;
        end
      end
      OP_BEACON_HOLD: begin
        if (hold_ms_i > beacon_left_q) begin
          beacon_left_d = hold_ms_i;
        end
      end
      default: begin
      end
    endcase

    send_valid_d = do_send;
    send_sess_d  = do_send ? pend_sess_d : 64'd0;
    send_nack_d  = do_send && pend_nack_d;

    if (awaiting_d && !confirmed_d) begin
      led_d = blink_phase_d < {1'b0, blink_half_q};
    end else if (confirmed_d && confirm_left_d != 16'd0) begin
      led_d = 1'b1;
    end else if (sess_active_d) begin
      led_d = !data_started_d || (since_data_d >= gap_cfg_q) || (pulse_left_d != 12'd0);
    end else begin
      led_d = 1'b0;
    end

    busy_d = sess_active_d || auto_ack_req_d || awaiting_d || (beacon_left_d != 16'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_half_q   <= BLINK_HALF_RST;
      pulse_cfg_q    <= PULSE_RST;
      gap_cfg_q      <= GAP_TIMEOUT_RST;
      confirm_cfg_q  <= CONFIRM_HLD_RST;
      retry_cfg_q    <= RETRY_WIN_RST;
      max_att_q      <= MAX_ATTEMPT_RST;
      debounce_cfg_q <= DEBOUNCE_RST;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_BLINK_HALF:  blink_half_q   <= pwdata[11:0];
        REG_PULSE:       pulse_cfg_q    <= pwdata[11:0];
        REG_GAP_TIMEOUT: gap_cfg_q      <= pwdata[11:0];
        REG_CONFIRM_HLD: confirm_cfg_q  <= pwdata[15:0];
        REG_RETRY_WIN:   retry_cfg_q    <= pwdata[11:0];
        REG_MAX_ATTEMPT: max_att_q      <= pwdata[2:0];
        REG_DEBOUNCE:    debounce_cfg_q <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nack_allowed_q  <= 1'b0;
      auto_ack_req_q  <= 1'b0;
      auto_ack_sess_q <= 64'd0;
      last_played_q   <= 64'd0;
      awaiting_q      <= 1'b0;
      confirmed_q     <= 1'b0;
      pend_nack_q     <= 1'b0;
      pend_sess_q     <= 64'd0;
      confirm_left_q  <= 16'd0;
      sess_active_q   <= 1'b0;
      data_started_q  <= 1'b0;
      since_data_q    <= 12'd0;
      pulse_left_q    <= 12'd0;
      beacon_left_q   <= 16'd0;
      blink_phase_q   <= 13'd0;
      attempts_q      <= 3'd0;
      window_left_q   <= 12'd0;
      debounce_left_q <= 8'd0;
      debounce_act_q  <= 1'b0;
      button_prev_q   <= 1'b1;
    end else if (accept) begin
      nack_allowed_q  <= nack_allowed_d;
      auto_ack_req_q  <= auto_ack_req_d;
      auto_ack_sess_q <= auto_ack_sess_d;
      last_played_q   <= last_played_d;
      awaiting_q      <= awaiting_d;
      confirmed_q     <= confirmed_d;
      pend_nack_q     <= pend_nack_d;
      pend_sess_q     <= pend_sess_d;
      confirm_left_q  <= confirm_left_d;
      sess_active_q   <= sess_active_d;
      data_started_q  <= data_started_d;
      since_data_q    <= since_data_d;
      pulse_left_q    <= pulse_left_d;
      beacon_left_q   <= beacon_left_d;
      blink_phase_q   <= blink_phase_d;
      attempts_q      <= attempts_d;
      window_left_q   <= window_left_d;
      debounce_left_q <= debounce_left_d;
      debounce_act_q  <= debounce_act_d;
      button_prev_q   <= button_prev_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      led_q        <= led_d;
      send_valid_q <= send_valid_d;
      send_sess_q  <= send_sess_d;
      send_nack_q  <= send_nack_d;
      matched_q    <= matched_d;
      busy_q       <= busy_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign led_o             = led_q;
  assign send_valid_o      = send_valid_q;
  assign send_session_o    = send_sess_q;
  assign send_is_nack_o    = send_nack_q;
  assign confirm_matched_o = matched_q;
  assign radio_busy_o      = busy_q;

endmodule

`default_nettype wire

// ----- test/tb_response_confirm_retry_led_control.sv -----
`default_nettype none

module tb_response_confirm_retry_led_control
  import rcrlc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] session;
    logic        is_nack;
    logic        button_level;
    logic [15:0] hold_ms;
  } request_t;

  typedef struct packed {
    logic        led;
    logic        send_valid;
    logic [63:0] send_session;
    logic        send_is_nack;
    logic        confirm_matched;
    logic        radio_busy;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  op_i = '0;
  logic [63:0] session_i = '0;
  logic        is_nack_i = 1'b0;
  logic        button_level_i = 1'b1;
  logic [15:0] hold_ms_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        led_o;
  logic        send_valid_o;
  logic [63:0] send_session_o;
  logic        send_is_nack_o;
  logic        confirm_matched_o;
  logic        radio_busy_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  response_confirm_retry_led_control DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .session_i        (session_i),
    .is_nack_i        (is_nack_i),
    .button_level_i   (button_level_i),
    .hold_ms_i        (hold_ms_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .led_o            (led_o),
    .send_valid_o     (send_valid_o),
    .send_session_o   (send_session_o),
    .send_is_nack_o   (send_is_nack_o),
    .confirm_matched_o(confirm_matched_o),
    .radio_busy_o     (radio_busy_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  result_t     expected_results[$];
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        btn_level = 1'b1;

  // Shadow copy of the block's registers and state.
  int unsigned cfg_blink_half, cfg_pulse, cfg_gap, cfg_confirm_hold;
  int unsigned cfg_retry_win, cfg_max_attempts, cfg_debounce;

  logic        nack_ok, ack_queued, awaiting, confirmed, pend_nack;
  logic        in_session, data_seen, debouncing, button_prev;
  logic [63:0] ack_session, last_played, pend_session;
  int unsigned confirm_left, since_data, pulse_left, beacon_left;
  int unsigned blink_phase, attempts, window_left, debounce_left;

  function automatic void clear_response();
    awaiting = 1'b0;
    confirmed = 1'b0;
    pend_nack = 1'b0;
    pend_session = '0;
    confirm_left = 0;
    attempts = 0;
    window_left = 0;
  endfunction

  function automatic void reset_model();
    cfg_blink_half   = BLINK_HALF_RST;
    cfg_pulse        = PULSE_RST;
    cfg_gap          = GAP_TIMEOUT_RST;
    cfg_confirm_hold = CONFIRM_HLD_RST;
    cfg_retry_win    = RETRY_WIN_RST;
    cfg_max_attempts = MAX_ATTEMPT_RST;
    cfg_debounce     = DEBOUNCE_RST;
    nack_ok = 1'b0;
    ack_queued = 1'b0;
    ack_session = '0;
    last_played = '0;
    clear_response();
    in_session = 1'b0;
    data_seen = 1'b0;
    since_data = 0;
    pulse_left = 0;
    beacon_left = 0;
    blink_phase = 0;
    debounce_left = 0;
    debouncing = 1'b0;
    button_prev = 1'b1;
  endfunction

  function automatic void extend_beacon(input int unsigned ms);
    if (ms > beacon_left) beacon_left = ms;
  endfunction

  function automatic void transmit(inout result_t r);
    attempts = (attempts + 1) & 7;
    window_left = cfg_retry_win;
    extend_beacon(SEND_HOLD_MS);
    r.send_valid = 1'b1;
    r.send_session = pend_session;
    r.send_is_nack = pend_nack;
  endfunction

  function automatic void begin_response(input logic nack, input logic [63:0] sess,
                                         inout result_t r);
    if (sess == '0) return;
    awaiting = 1'b1;
    confirmed = 1'b0;
    confirm_left = 0;
    pend_nack = nack;
    pend_session = sess;
    beacon_left = ACK_HOLD_MS;
    blink_phase = 0;
    attempts = 0;
    transmit(r);
  endfunction

  function automatic void ms_tick(input logic level, inout result_t r);
    logic        ack_now;
    logic [63:0] ack_sess;
    logic        nack_now;
    ack_now = 1'b0;
    ack_sess = '0;
    nack_now = 1'b0;
    if (confirm_left != 0) confirm_left--;
    if (pulse_left != 0) pulse_left--;
    if (beacon_left != 0) beacon_left--;
    if (since_data < SINCE_MAX) since_data++;
    if (awaiting && !confirmed) begin
      blink_phase++;
      if (blink_phase >= 2 * cfg_blink_half) blink_phase = 0;
    end
    if (confirmed && confirm_left == 0) begin
      confirmed = 1'b0;
      pend_nack = 1'b0;
      pend_session = '0;
    end
    if (awaiting) begin
      if (window_left != 0) window_left--;
      if (window_left == 0) begin
        if (attempts < cfg_max_attempts) transmit(r);
        else clear_response();
      end
    end else if (debouncing) begin
      if (debounce_left != 0) debounce_left--;
      if (debounce_left == 0) begin
        debouncing = 1'b0;
        if (!level) begin_response(1'b1, last_played, r);
      end
    end else begin
      if (ack_queued) begin
        ack_now = 1'b1;
        ack_sess = ack_session;
        ack_queued = 1'b0;
      end
      if (!ack_now && nack_ok && button_prev && !level) begin
        if (cfg_debounce == 0) begin
          nack_now = 1'b1;
        end else begin
          debouncing = 1'b1;
          debounce_left = cfg_debounce;
        end
      end
      button_prev = level;
      if (ack_now) begin_response(1'b0, ack_sess, r);
      else if (nack_now) begin_response(1'b1, last_played, r);
    end
  endfunction

  function automatic logic led_now();
    if (awaiting && !confirmed) return blink_phase < cfg_blink_half;
    if (confirmed && confirm_left > 0) return 1'b1;
    if (in_session) begin
      if (!data_seen || since_data >= cfg_gap) return 1'b1;
      return pulse_left > 0;
    end
    return 1'b0;
  endfunction

  function automatic result_t predict_result(input request_t q);
    result_t r;
    r = '0;
    case (q.op)
      OP_TICK: ms_tick(q.button_level, r);
      OP_NEW_SESSION: begin
        nack_ok = 1'b0;
        ack_queued = 1'b0;
        ack_session = '0;
        last_played = '0;
        clear_response();
        in_session = 1'b1;
        data_seen = 1'b0;
        since_data = 0;
        pulse_left = 0;
        beacon_left = ACK_HOLD_MS;
      end
      OP_DATA_PACKET: begin
        in_session = 1'b1;
        data_seen = 1'b1;
        since_data = 0;
        pulse_left = cfg_pulse;
        beacon_left = EVENT_HOLD_MS;
      end
      OP_END_AUDIO: begin
        in_session = 1'b0;
        data_seen = 1'b0;
        pulse_left = 0;
        beacon_left = EVENT_HOLD_MS;
      end
      OP_PLAYBACK_END: begin
        if (q.session != '0) begin
          last_played = q.session;
          nack_ok = 1'b1;
          ack_session = q.session;
          ack_queued = 1'b1;
          beacon_left = ACK_HOLD_MS;
        end
      end
      OP_CONFIRM: begin
        if (awaiting && q.session == pend_session && q.is_nack == pend_nack) begin
          confirmed = 1'b1;
          awaiting = 1'b0;
          attempts = 0;
          window_left = 0;
          confirm_left = cfg_confirm_hold;
          nack_ok = 1'b1;
          beacon_left = EVENT_HOLD_MS;
          r.confirm_matched = 1'b1;
        end
      end
      OP_BEACON_HOLD: extend_beacon(q.hold_ms);
      default: ;
    endcase
    r.led = led_now();
    r.radio_busy = in_session || ack_queued || awaiting || beacon_left > 0;
    return r;
  endfunction

  function automatic request_t req(input logic [2:0] op, input logic [63:0] sess,
                                   input logic nack, input logic level,
                                   input logic [15:0] hold);
    request_t q;
    q.op = op;
    q.session = sess;
    q.is_nack = nack;
    q.button_level = level;
    q.hold_ms = hold;
    return q;
  endfunction

  function automatic logic [63:0] pick_session();
    case ($urandom_range(7))
      0: return 64'd1;
      1: return 64'd2;
      2: return '1;
      3: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic request_t random_request();
    request_t    q;
    int unsigned pick;
    q.op = OP_TICK;
    q.session = {$urandom, $urandom};
    q.is_nack = 1'($urandom_range(1));
    q.button_level = 1'($urandom_range(1));
    q.hold_ms = 16'($urandom_range(16'hFFFF));
    pick = $urandom_range(99);
    if (pick < 58) begin
      if ($urandom_range(19) == 0) btn_level = ~btn_level;
      if (pick < 54) q.button_level = btn_level;
    end else if (pick < 68) begin
      q.op = OP_CONFIRM;
      if (awaiting && $urandom_range(3) != 0) begin
        q.session = pend_session;
        q.is_nack = pend_nack;
      end else if ($urandom_range(1) != 0) begin
        q.session = pick_session();
      end
    end else if (pick < 76) begin
      q.op = OP_PLAYBACK_END;
      q.session = pick_session();
    end else if (pick < 82) begin
      q.op = OP_DATA_PACKET;
    end else if (pick < 86) begin
      q.op = OP_NEW_SESSION;
    end else if (pick < 90) begin
      q.op = OP_END_AUDIO;
    end else if (pick < 97) begin
      q.op = OP_BEACON_HOLD;
      if ($urandom_range(1) != 0) q.hold_ms = 16'($urandom_range(2000));
    end else begin
      q.op = OP_UNUSED;
    end
    return q;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch in %s at result %0d: got %0h, expected %0h",
             what, results_seen, got, want);
    errors++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Called at a rising edge; returns at the edge that accepts the request.
  task automatic drive_request(input request_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= q.op;
    session_i <= q.session;
    is_nack_i <= q.is_nack;
    button_level_i <= q.button_level;
    hold_ms_i <= q.hold_ms;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_result(q));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_BLINK_HALF:  cfg_blink_half = value & 12'hFFF;
      REG_PULSE:       cfg_pulse = value & 12'hFFF;
      REG_GAP_TIMEOUT: cfg_gap = value & 12'hFFF;
      REG_CONFIRM_HLD: cfg_confirm_hold = value & 16'hFFFF;
      REG_RETRY_WIN:   cfg_retry_win = value & 12'hFFF;
      REG_MAX_ATTEMPT: cfg_max_attempts = value & 3'h7;
      REG_DEBOUNCE:    cfg_debounce = value & 8'hFF;
      default: ;
    endcase
  endtask

  task automatic program_regs(input int unsigned blink, input int unsigned pulse,
                              input int unsigned gap, input int unsigned hold,
                              input int unsigned win, input int unsigned tries,
                              input int unsigned deb);
    wait_drained();
    write_reg(REG_BLINK_HALF, blink);
    write_reg(REG_PULSE, pulse);
    write_reg(REG_GAP_TIMEOUT, gap);
    write_reg(REG_CONFIRM_HLD, hold);
    write_reg(REG_RETRY_WIN, win);
    write_reg(REG_MAX_ATTEMPT, tries);
    write_reg(REG_DEBOUNCE, deb);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_random_regs();
    program_regs($urandom_range(6), $urandom_range(8, 1), $urandom_range(12, 1),
                 $urandom_range(20, 1), $urandom_range(10), $urandom_range(7),
                 $urandom_range(6));
  endtask

  task automatic test_reset_state();
    drive_request(req(OP_UNUSED, '1, 1'b1, 1'b0, '1));
    drive_request(req(OP_TICK, '0, 1'b0, 1'b1, '0));
    drive_request(req(OP_TICK, '0, 1'b0, 1'b0, '0));
    drive_request(req(OP_TICK, '0, 1'b0, 1'b1, '0));
  endtask

  task automatic test_auto_ack_confirm();
    program_regs(1, 2, 3, 3, 2, 2, 1);
    drive_request(req(OP_NEW_SESSION, 64'h1234, 1'b0, 1'b1, '0));
    drive_request(req(OP_DATA_PACKET, '0, 1'b0, 1'b1, '0));
    repeat (2) drive_request(req(OP_TICK, '0, 1'b0, 1'b1, '0));
    drive_request(req(OP_PLAYBACK_END, '0, 1'b0, 1'b1, '0));
    drive_request(req(OP_PLAYBACK_END, '1, 1'b0, 1'b1, '0));
    drive_request(req(OP_TICK, '0, 1'b0, 1'b1, '0));
    drive_request(req(OP_CONFIRM, '1, 1'b1, 1'b1, '0));
    repeat (2) drive_request(req(OP_TICK, '0, 1'b0, 1'b1, '0));
    drive_request(req(OP_CONFIRM, '1, 1'b0, 1'b1, '0));
    repeat (3) drive_request(req(OP_TICK, '0, 1'b0, 1'b1, '0));
    drive_request(req(OP_BEACON_HOLD, '0, 1'b0, 1'b1, 16'hFFFF));
    drive_request(req(OP_BEACON_HOLD, '0, 1'b0, 1'b1, 16'h0000));
    drive_request(req(OP_END_AUDIO, '0, 1'b0, 1'b1, '0));
  endtask

  task automatic test_button_nack_retry();
    repeat (2) drive_request(req(OP_TICK, '0, 1'b0, 1'b0, '0));
    repeat (5) drive_request(req(OP_TICK, '0, 1'b0, 1'b1, '0));
  endtask

  task automatic test_zero_settings();
    program_regs(0, 12'hFFF, 12'hFFF, 16'hFFFF, 0, 0, 0);
    drive_request(req(OP_PLAYBACK_END, 64'd5, 1'b0, 1'b1, '0));
    repeat (2) drive_request(req(OP_TICK, '0, 1'b0, 1'b1, '0));
    drive_request(req(OP_TICK, '0, 1'b0, 1'b0, '0));
    drive_request(req(OP_CONFIRM, 64'd5, 1'b1, 1'b1, '0));
    drive_request(req(OP_PLAYBACK_END, 64'd9, 1'b0, 1'b1, '0));
    drive_request(req(OP_TICK, '0, 1'b0, 1'b1, '0));
    drive_request(req(OP_NEW_SESSION, '0, 1'b0, 1'b1, '0));
    drive_request(req(OP_TICK, '0, 1'b0, 1'b1, '0));
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) drive_request(random_request());
  endtask

  always @(posedge clk_i) begin : result_monitor
    result_t got;
    result_t want;
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {led_o, send_valid_o, send_session_o, send_is_nack_o, confirm_matched_o,
             radio_busy_o};
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", got.send_session, '0);
      end else begin
        want = expected_results.pop_front();
        check_field("led", got.led, want.led);
        check_field("send_valid", got.send_valid, want.send_valid);
        check_field("send_session", got.send_session, want.send_session);
        check_field("send_is_nack", got.send_is_nack, want.send_is_nack);
        check_field("confirm_matched", got.confirm_matched, want.confirm_matched);
        check_field("radio_busy", got.radio_busy, want.radio_busy);
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    reset_model();
    send_idle_pct = 13;
    recv_idle_pct = 76;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_auto_ack_confirm();
    test_button_nack_retry();
    test_zero_settings();
    program_random_regs();
    test_random_traffic(200);
    program_regs(12'hFFF, 12'hFFF, 12'hFFF, 16'hFFFF, 12'hFFF, 7, 8'hFF);
    test_random_traffic(150);

    send_idle_pct = 76;
    recv_idle_pct = 13;
    program_regs(1, 1, 1, 1, 1, 1, 0);
    test_random_traffic(150);
    program_random_regs();
    test_random_traffic(150);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_random_regs();
    test_random_traffic(150);
    program_random_regs();
    test_random_traffic(150);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
